// ===== rtl/saa_pkg.sv =====
// ----------------------------------------------------------------------------
// saa_pkg
// Shared types and constants of the segmented append allocator.
// ----------------------------------------------------------------------------
package saa_pkg;

    localparam int WRITERS       = 8;
    localparam int WR_W          = $clog2(WRITERS);
    localparam int LEN_W         = 21;
    localparam int LIST_CAPACITY = 1048576;
    localparam int GAP_W         = 17;
    localparam int DATA_W        = 64;
    localparam int SLOT_W        = 20;

    localparam logic [GAP_W-1:0] GAP_MAX   = GAP_W'(65536);
    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(1024);
    localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(LIST_CAPACITY);

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_COLLECT = 2'd1,
        OP_SHRINK  = 2'd2,
        OP_GROW    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_SLOT   = 2'd0,
        KIND_MOVE   = 2'd1,
        KIND_LENGTH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_ILLEGAL  = 2'd2
    } status_t;

    typedef enum logic {
        REG_GAP   = 1'b0,
        REG_LIMIT = 1'b1
    } reg_addr_t;

endpackage

// ===== rtl/segmented_append_allocator_top.sv =====
// ----------------------------------------------------------------------------
// segmented_append_allocator_top
// Hands out list slots to writers from per-writer segments, shrinks and
// grows the list, and plans the compaction moves of a collect.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/operation/writer/item_value/new_length while busy
//   is low. Results leave on the result ports, marked by result_valid for one
//   cycle each; last marks the final result of a command. Results cannot be
//   stalled. The segment gap (0x0) and list_limit (0x4) are written over APB
//   only while the block is idle: a rule for the user, not enforced by the block.
// Timing:
//   Push, shrink and grow give a single result beat: S_IDLE accepts the
//   command and S_EXEC registers the result, and the next command can be
//   accepted at the edge that ends that beat. A collect runs an insertion sort
//   with one shared compare/swap unit (one step per cycle, at most
//   WRITERS*(WRITERS-1)/2 swaps plus WRITERS passes), then one move per
//   cycle with one shared subtract/compare unit, then the length report;
//   busy stays high from the start edge until the length report is out.
// Reset:
//   All segments, the length and the peak clear to zero; gap_reg is 1024
//   and list_limit 1048576.
// ----------------------------------------------------------------------------
module segmented_append_allocator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [2:0]  writer,
    input  logic [63:0] item_value,
    input  logic [20:0] new_length,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [1:0]  status,
    output logic [19:0] slot_index,
    output logic [63:0] slot_data,
    output logic [20:0] move_dest,
    output logic [20:0] move_src,
    output logic [16:0] move_count,
    output logic [20:0] list_length,
    output logic [20:0] longest_length,
    output logic        last
);

    localparam int LW = saa_pkg::LEN_W;
    localparam int WW = saa_pkg::WR_W;
    localparam int NW = saa_pkg::WRITERS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SORT,
        S_FIX,
        S_PAIR,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic [saa_pkg::GAP_W-1:0] gap_reg;
    logic [LW-1:0]             limit_reg;

    logic [LW-1:0] s_reg [NW];
    logic [LW-1:0] e_reg [NW];
    logic [LW-1:0] n_reg [NW];
    logic [LW-1:0] total_reg;
    logic [LW-1:0] peak_reg;

    logic [1:0]    op_reg;
    logic [WW-1:0] wr_reg;
    logic [63:0]   item_reg;
    logic [LW-1:0] nl_reg;

    // sort cursors and pair pointers
    logic [WW:0]   i_reg;
    logic [WW-1:0] j_reg;
    logic [WW-1:0] low_reg;
    logic [WW-1:0] high_reg;

    // ---------------- configuration port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (saa_pkg::reg_addr_t'(paddr[2]))
            saa_pkg::REG_GAP:   prdata = 32'(gap_reg);
            saa_pkg::REG_LIMIT: prdata = 32'(limit_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg   <= saa_pkg::GAP_RESET;
            limit_reg <= saa_pkg::LIMIT_MAX;
        end
        else if (cfg_wr)
        begin
            if (saa_pkg::reg_addr_t'(paddr[2]) == saa_pkg::REG_GAP)
                gap_reg <= pwdata[saa_pkg::GAP_W-1:0];
            else
                limit_reg <= pwdata[LW-1:0];
        end
    end

    // effective gap and limit
    logic [saa_pkg::GAP_W-1:0] eff_gap;
    logic [LW-1:0]             eff_limit;
    always_comb
    begin
        if (gap_reg == '0)
            eff_gap = saa_pkg::GAP_W'(1);
        else if (gap_reg > saa_pkg::GAP_MAX)
            eff_gap = saa_pkg::GAP_MAX;
        else
            eff_gap = gap_reg;
        eff_limit = (limit_reg > saa_pkg::LIMIT_MAX) ? saa_pkg::LIMIT_MAX : limit_reg;
    end

    // ---------------- shared unit: push claim arithmetic
    logic [LW:0]   claim_end;
    logic          seg_full;
    logic          claim_ovf;
    assign seg_full  = (n_reg[wr_reg] == e_reg[wr_reg]);
    assign claim_end = {1'b0, total_reg} + (LW+1)'(eff_gap);
    assign claim_ovf = claim_end > {1'b0, eff_limit};

    // ---------------- shared unit: pair room/fill
    logic [LW-1:0] room;
    logic [LW-1:0] fill;
    logic          take_room;
    logic [LW-1:0] cnt;
    always_comb
    begin
        room      = (e_reg[low_reg] >= n_reg[low_reg]) ? e_reg[low_reg] - n_reg[low_reg] : '0;
        fill      = (n_reg[high_reg] >= s_reg[high_reg]) ?
                    n_reg[high_reg] - s_reg[high_reg] : '0;
        take_room = (room <= fill);
        cnt       = take_room ? room : fill;
    end

    // sort compare: element j-1 against j
    logic [WW-1:0] jm1;
    logic          do_swap;
    assign jm1     = j_reg - WW'(1);
    assign do_swap = (j_reg != '0) && (e_reg[jm1] > e_reg[j_reg]);

    logic [LW-1:0] newlen;
    assign newlen = (n_reg[low_reg] > total_reg) ? total_reg : n_reg[low_reg];

    assign busy = (state_reg != S_IDLE);

    // ---------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            result_valid <= 1'b0;
            total_reg    <= '0;
            peak_reg     <= '0;
            for (int k = 0; k < NW; k++)
            begin
                s_reg[k] <= '0;
                e_reg[k] <= '0;
                n_reg[k] <= '0;
            end
            i_reg    <= '0;
            j_reg    <= '0;
            low_reg  <= '0;
            high_reg <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg   <= operation;
                        wr_reg   <= writer[WW-1:0];
                        item_reg <= item_value;
                        nl_reg   <= new_length;
                        if (saa_pkg::op_t'(operation) == saa_pkg::OP_COLLECT)
                        begin
                            i_reg     <= (WW+1)'(1);
                            j_reg     <= WW'(1);
                            state_reg <= S_SORT;
                        end
                        else
                            state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    result_valid   <= 1'b1;
                    last           <= 1'b1;
                    result_kind    <= saa_pkg::KIND_SLOT;
                    status         <= saa_pkg::ST_OK;
                    slot_index     <= '0;
                    slot_data      <= '0;
                    move_dest      <= '0;
                    move_src       <= '0;
                    move_count     <= '0;
                    list_length    <= total_reg;
                    longest_length <= peak_reg;
                    state_reg      <= S_IDLE;
                    unique case (saa_pkg::op_t'(op_reg))
                        saa_pkg::OP_PUSH:
                        begin
                            if (seg_full && claim_ovf)
                                status <= saa_pkg::ST_OVERFLOW;
                            else if (seg_full)
                            begin
                                total_reg      <= claim_end[LW-1:0];
                                e_reg[wr_reg]  <= claim_end[LW-1:0];
                                s_reg[wr_reg]  <= total_reg;
                                n_reg[wr_reg]  <= total_reg + LW'(1);
                                slot_index     <= total_reg[saa_pkg::SLOT_W-1:0];
                                slot_data      <= item_reg;
                                list_length    <= claim_end[LW-1:0];
                            end
                            else
                            begin
                                n_reg[wr_reg] <= n_reg[wr_reg] + LW'(1);
                                slot_index    <= n_reg[wr_reg][saa_pkg::SLOT_W-1:0];
                                slot_data     <= item_reg;
                            end
                        end
                        saa_pkg::OP_SHRINK:
                        begin
                            result_kind <= saa_pkg::KIND_LENGTH;
                            if (nl_reg > total_reg)
                                status <= saa_pkg::ST_ILLEGAL;
                            else
                            begin
                                total_reg   <= nl_reg;
                                list_length <= nl_reg;
                                for (int k = 0; k < NW; k++)
                                begin
                                    s_reg[k] <= nl_reg;
                                    e_reg[k] <= nl_reg;
                                    n_reg[k] <= nl_reg;
                                end
                            end
                        end
                        saa_pkg::OP_GROW:
                        begin
                            result_kind <= saa_pkg::KIND_LENGTH;
                            if (nl_reg < total_reg)
                                status <= saa_pkg::ST_ILLEGAL;
                            else if (nl_reg >= eff_limit)
                                status <= saa_pkg::ST_OVERFLOW;
                            else
                            begin
                                total_reg   <= nl_reg;
                                list_length <= nl_reg;
                                if (nl_reg > peak_reg)
                                begin
                                    peak_reg       <= nl_reg;
                                    longest_length <= nl_reg;
                                end
                                for (int k = 0; k < NW; k++)
                                begin
                                    s_reg[k] <= nl_reg;
                                    e_reg[k] <= nl_reg;
                                    n_reg[k] <= nl_reg;
                                end
                            end
                        end
                        default:
                            state_reg <= S_IDLE;
                    endcase
                end
                // insertion sort, one compare/swap per cycle; stable
                S_SORT:
                begin
                    if (i_reg >= (WW+1)'(NW))
                        state_reg <= S_FIX;
                    else if (do_swap)
                    begin
                        s_reg[jm1]   <= s_reg[j_reg];
                        e_reg[jm1]   <= e_reg[j_reg];
                        n_reg[jm1]   <= n_reg[j_reg];
                        s_reg[j_reg] <= s_reg[jm1];
                        e_reg[j_reg] <= e_reg[jm1];
                        n_reg[j_reg] <= n_reg[jm1];
                        j_reg        <= jm1;
                    end
                    else
                    begin
                        i_reg <= i_reg + (WW+1)'(1);
                        j_reg <= i_reg[WW-1:0] + WW'(1);
                    end
                end
                S_FIX:
                begin
                    for (int k = 1; k < NW; k++)
                        s_reg[k] <= e_reg[k-1];
                    low_reg   <= '0;
                    high_reg  <= WW'(NW - 1);
                    state_reg <= S_PAIR;
                end
                // one move per cycle
                S_PAIR:
                begin
                    if (high_reg > low_reg)
                    begin
                        result_valid    <= 1'b1;
                        last            <= 1'b0;
                        result_kind     <= saa_pkg::KIND_MOVE;
                        status          <= saa_pkg::ST_OK;
                        slot_index      <= '0;
                        slot_data       <= '0;
                        move_dest       <= n_reg[low_reg];
                        move_src        <= n_reg[high_reg] - cnt;
                        move_count      <= cnt[saa_pkg::GAP_W-1:0];
                        list_length     <= '0;
                        longest_length  <= '0;
                        n_reg[high_reg] <= n_reg[high_reg] - cnt;
                        if (take_room)
                            low_reg <= low_reg + WW'(1);
                        else
                        begin
                            n_reg[low_reg] <= n_reg[low_reg] + cnt;
                            high_reg       <= high_reg - WW'(1);
                        end
                    end
                    else
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    total_reg <= newlen;
                    for (int k = 0; k < NW; k++)
                    begin
                        s_reg[k] <= newlen;
                        e_reg[k] <= newlen;
                        n_reg[k] <= newlen;
                    end
                    if (newlen > peak_reg)
                        peak_reg <= newlen;
                    result_valid   <= 1'b1;
                    last           <= 1'b1;
                    result_kind    <= saa_pkg::KIND_LENGTH;
                    status         <= saa_pkg::ST_OK;
                    slot_index     <= '0;
                    slot_data      <= '0;
                    move_dest      <= '0;
                    move_src       <= '0;
                    move_count     <= '0;
                    list_length    <= newlen;
                    longest_length <= (newlen > peak_reg) ? newlen : peak_reg;
                    state_reg      <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_peak_ge_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && $past(state_reg) == S_FINISH) |-> peak_reg >= total_reg)
        else $error("peak below length after collect");
    a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command not taken");
    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == S_EXEC |-> (result_valid && last))
        else $error("single result missing");
    a_total_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= saa_pkg::LIMIT_MAX)
        else $error("length beyond capacity");
`endif

endmodule
